/* rtl/sip_pkg.sv */
// Shared constants and types for the segment intersection point core.
package sip_pkg;

  // default coordinate format, signed Q15.8
  localparam int SIP_COORD_BITS = 24;
  localparam int SIP_FRAC_BITS  = 8;

  // per-word control that rides along with the divider stages
  typedef struct packed {
    logic hit;
    logic par;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } sip_ctl_t;

endpackage

/* rtl/sip_div_pipe.sv */
// Pipelined restoring divider: two dividends over one divisor, one quotient bit per stage.
module sip_div_pipe #(
  parameter int COORD_BITS = sip_pkg::SIP_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  output logic                              in_rdy,
  input  sip_pkg::sip_ctl_t                 in_ctl,
  input  logic [3*COORD_BITS+3:0]           in_nx,
  input  logic [3*COORD_BITS+3:0]           in_ny,
  input  logic [2*COORD_BITS+2:0]           in_d,
  output logic                              out_vld,
  input  logic                              out_rdy,
  output sip_pkg::sip_ctl_t                 out_ctl,
  output logic [COORD_BITS-2:0]             out_qx,
  output logic [COORD_BITS-2:0]             out_qy
);
  import sip_pkg::*;

  localparam int WN   = 3*COORD_BITS+4;
  localparam int WDET = 2*COORD_BITS+3;
  localparam int Q    = COORD_BITS-1;

  logic [WN-1:0]   rx_r [Q];
  logic [WN-1:0]   ry_r [Q];
  logic [Q-1:0]    qx_r [Q];
  logic [Q-1:0]    qy_r [Q];
  logic [WDET-1:0] d_r  [Q];
  sip_ctl_t        ctl_r [Q];
  logic [Q-1:0]    v_r;
  logic [Q:0]      rdy;

  // a stage loads when it is empty or the one after it moves
  always_comb begin
    rdy[Q] = out_rdy;
    for (int j = Q-1; j >= 0; j--) begin
      rdy[j] = !v_r[j] || rdy[j+1];
    end
  end

  assign in_rdy = rdy[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_vld;
      end
      for (int j = 1; j < Q; j++) begin
        if (rdy[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
    end
  end

  // one trial subtract per stage, quotient bit SH
  for (genvar j = 0; j < Q; j++) begin : g_stg
    localparam int SH = Q-1-j;
    logic [WN-1:0]   rx_prev, ry_prev, dsh, rx_nxt, ry_nxt;
    logic [Q-1:0]    qx_prev, qy_prev, qx_nxt, qy_nxt;
    logic [WDET-1:0] d_prev;
    sip_ctl_t        ctl_prev;
    logic            gx, gy;

    if (j == 0) begin : g_first
      assign rx_prev  = in_nx;
      assign ry_prev  = in_ny;
      assign qx_prev  = '0;
      assign qy_prev  = '0;
      assign d_prev   = in_d;
      assign ctl_prev = in_ctl;
    end else begin : g_next
      assign rx_prev  = rx_r[j-1];
      assign ry_prev  = ry_r[j-1];
      assign qx_prev  = qx_r[j-1];
      assign qy_prev  = qy_r[j-1];
      assign d_prev   = d_r[j-1];
      assign ctl_prev = ctl_r[j-1];
    end

    assign dsh    = WN'(d_prev) << SH;
    assign gx     = rx_prev >= dsh;
    assign gy     = ry_prev >= dsh;
    assign rx_nxt = gx ? rx_prev - dsh : rx_prev;
    assign ry_nxt = gy ? ry_prev - dsh : ry_prev;
    assign qx_nxt = qx_prev | (gx ? (Q'(1) << SH) : Q'(0));
    assign qy_nxt = qy_prev | (gy ? (Q'(1) << SH) : Q'(0));

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        rx_r[j]  <= rx_nxt;
        ry_r[j]  <= ry_nxt;
        qx_r[j]  <= qx_nxt;
        qy_r[j]  <= qy_nxt;
        d_r[j]   <= d_prev;
        ctl_r[j] <= ctl_prev;
      end
    end
  end

  assign out_vld = v_r[Q-1];
  assign out_ctl = ctl_r[Q-1];
  assign out_qx  = qx_r[Q-1];
  assign out_qy  = qy_r[Q-1];

endmodule

/* rtl/segment_intersection_point_core.sv */
// Top level: segment pair in, touch/cross flags and intersection point out.
//
//  channel | ports                               | direction | handshake
//  --------+-------------------------------------+-----------+---------------------
//  in      | in_a_*, in_b_* (8 x COORD_BITS)     | to core   | in_valid / in_stall
//  out     | out_hit, out_parallel_hit, out_point| from core | out_valid / out_stall
//
//  One word enters per cycle while in_stall is low; the path is eight front stages,
//  COORD_BITS-1 divider stages and one output register. Throughput is one word per
//  cycle without out_stall; the divider resolves one quotient bit per stage.
//  rst_n (synchronous) empties every stage; payload registers are not reset.
//  A stall holds only the stages behind a full one; bubbles still close up.
module segment_intersection_point_core #(
  parameter int COORD_BITS = sip_pkg::SIP_COORD_BITS,
  parameter int FRAC_BITS  = sip_pkg::SIP_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_a_start_x,
  input  logic signed [COORD_BITS-1:0] in_a_start_y,
  input  logic signed [COORD_BITS-1:0] in_a_end_x,
  input  logic signed [COORD_BITS-1:0] in_a_end_y,
  input  logic signed [COORD_BITS-1:0] in_b_start_x,
  input  logic signed [COORD_BITS-1:0] in_b_start_y,
  input  logic signed [COORD_BITS-1:0] in_b_end_x,
  input  logic signed [COORD_BITS-1:0] in_b_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic                         out_parallel_hit,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y
);
  import sip_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int D    = C+1;
  localparam int P    = 2*D;
  localparam int WC   = 2*C+2;
  localparam int WDET = 2*C+3;
  localparam int CH   = C+2;
  localparam int PH   = 2*C+3;
  localparam int PL   = 2*C+2;
  localparam int WN   = 3*C+4;
  localparam int Q    = C-1;
  localparam int NF   = 8;

  localparam logic [1:0] ORI_COL = 2'd0;
  localparam logic [1:0] ORI_POS = 2'd1;
  localparam logic [1:0] ORI_NEG = 2'd2;

  localparam longint          PAR_L  = -(longint'(1) <<< FRAC_BITS);
  localparam logic [C-1:0]    PAR_PT = C'(PAR_L);
  localparam logic [C-1:0]    C_MAX  = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0]    C_MIN  = {1'b1, {(C-1){1'b0}}};

  // front pipeline flow control
  logic [NF:1]   fv_r;
  logic [NF+1:1] frdy;
  logic          div_in_rdy, div_out_vld, o_rdy;

  always_comb begin
    frdy[NF+1] = div_in_rdy;
    for (int k = NF; k >= 1; k--) begin
      frdy[k] = !fv_r[k] || frdy[k+1];
    end
  end

  assign in_stall = !frdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      if (frdy[1]) begin
        fv_r[1] <= in_valid;
      end
      for (int k = 2; k <= NF; k++) begin
        if (frdy[k]) begin
          fv_r[k] <= fv_r[k-1];
        end
      end
    end
  end

  function automatic logic btw(input logic signed [C-1:0] p, input logic signed [C-1:0] q,
                               input logic signed [C-1:0] r);
    btw = (q >= p && q <= r) || (q >= r && q <= p);
  endfunction

  // ---------------- stage 1: edge vectors and bounding boxes
  logic signed [D-1:0] s1_a1_nxt, s1_b1_nxt, s1_a2_nxt, s1_b2_nxt;
  logic signed [D-1:0] s1_ex_nxt [4];
  logic signed [D-1:0] s1_ey_nxt [4];
  logic [3:0]          s1_box_nxt;
  logic signed [D-1:0] s1_a1_r, s1_b1_r, s1_a2_r, s1_b2_r;
  logic signed [D-1:0] s1_ex_r [4];
  logic signed [D-1:0] s1_ey_r [4];
  logic signed [C-1:0] s1_x0_r, s1_y0_r, s1_x2_r, s1_y2_r;
  logic [3:0]          s1_box_r;

  always_comb begin
    s1_a1_nxt    = D'(in_a_end_y)   - D'(in_a_start_y);
    s1_b1_nxt    = D'(in_a_start_x) - D'(in_a_end_x);
    s1_a2_nxt    = D'(in_b_end_y)   - D'(in_b_start_y);
    s1_b2_nxt    = D'(in_b_start_x) - D'(in_b_end_x);
    s1_ex_nxt[0] = D'(in_b_start_x) - D'(in_a_end_x);
    s1_ey_nxt[0] = D'(in_b_start_y) - D'(in_a_end_y);
    s1_ex_nxt[1] = D'(in_b_end_x)   - D'(in_a_end_x);
    s1_ey_nxt[1] = D'(in_b_end_y)   - D'(in_a_end_y);
    s1_ex_nxt[2] = D'(in_a_start_x) - D'(in_b_end_x);
    s1_ey_nxt[2] = D'(in_a_start_y) - D'(in_b_end_y);
    s1_ex_nxt[3] = D'(in_a_end_x)   - D'(in_b_end_x);
    s1_ey_nxt[3] = D'(in_a_end_y)   - D'(in_b_end_y);
    s1_box_nxt[0] = btw(in_a_start_x, in_b_start_x, in_a_end_x)
                 && btw(in_a_start_y, in_b_start_y, in_a_end_y);
    s1_box_nxt[1] = btw(in_a_start_x, in_b_end_x, in_a_end_x)
                 && btw(in_a_start_y, in_b_end_y, in_a_end_y);
    s1_box_nxt[2] = btw(in_b_start_x, in_a_start_x, in_b_end_x)
                 && btw(in_b_start_y, in_a_start_y, in_b_end_y);
    s1_box_nxt[3] = btw(in_b_start_x, in_a_end_x, in_b_end_x)
                 && btw(in_b_start_y, in_a_end_y, in_b_end_y);
  end

  always_ff @(posedge clk) begin
    if (frdy[1]) begin
      s1_a1_r  <= s1_a1_nxt;
      s1_b1_r  <= s1_b1_nxt;
      s1_a2_r  <= s1_a2_nxt;
      s1_b2_r  <= s1_b2_nxt;
      s1_ex_r  <= s1_ex_nxt;
      s1_ey_r  <= s1_ey_nxt;
      s1_x0_r  <= in_a_start_x;
      s1_y0_r  <= in_a_start_y;
      s1_x2_r  <= in_b_start_x;
      s1_y2_r  <= in_b_start_y;
      s1_box_r <= s1_box_nxt;
    end
  end

  // ---------------- stage 2: cross and line products
  logic signed [P-1:0] s2_po_nxt [4];
  logic signed [P-1:0] s2_pq_nxt [4];
  logic signed [P-1:0] s2_pc_nxt [4];
  logic signed [P-1:0] s2_po_r [4];
  logic signed [P-1:0] s2_pq_r [4];
  logic signed [P-1:0] s2_pc_r [4];
  logic signed [P-1:0] s2_pd1_r, s2_pd2_r;
  logic signed [D-1:0] s2_a1_r, s2_b1_r, s2_a2_r, s2_b2_r;
  logic [3:0]          s2_box_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s2_po_nxt[k] = P'((k < 2) ? s1_a1_r : s1_a2_r) * P'(s1_ex_r[k]);
      s2_pq_nxt[k] = P'((k < 2) ? s1_b1_r : s1_b2_r) * P'(s1_ey_r[k]);
    end
    s2_pc_nxt[0] = P'(s1_a1_r) * P'(s1_x0_r);
    s2_pc_nxt[1] = P'(s1_b1_r) * P'(s1_y0_r);
    s2_pc_nxt[2] = P'(s1_a2_r) * P'(s1_x2_r);
    s2_pc_nxt[3] = P'(s1_b2_r) * P'(s1_y2_r);
  end

  always_ff @(posedge clk) begin
    if (frdy[2]) begin
      s2_po_r  <= s2_po_nxt;
      s2_pq_r  <= s2_pq_nxt;
      s2_pc_r  <= s2_pc_nxt;
      s2_pd1_r <= P'(s1_a1_r) * P'(s1_b2_r);
      s2_pd2_r <= P'(s1_a2_r) * P'(s1_b1_r);
      s2_a1_r  <= s1_a1_r;
      s2_b1_r  <= s1_b1_r;
      s2_a2_r  <= s1_a2_r;
      s2_b2_r  <= s1_b2_r;
      s2_box_r <= s1_box_r;
    end
  end

  // ---------------- stage 3: orientation codes, c terms, determinant
  logic signed [P:0]      s3_sum [4];
  logic [1:0]             s3_ori_nxt [4];
  logic [1:0]             s3_ori_r [4];
  logic signed [WC-1:0]   s3_c1_r, s3_c2_r;
  logic signed [WDET-1:0] s3_det_r;
  logic signed [D-1:0]    s3_a1_r, s3_b1_r, s3_a2_r, s3_b2_r;
  logic [3:0]             s3_box_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s3_sum[k] = (P+1)'(s2_po_r[k]) + (P+1)'(s2_pq_r[k]);
      if (s3_sum[k] == '0) begin
        s3_ori_nxt[k] = ORI_COL;
      end else if (s3_sum[k][P]) begin
        s3_ori_nxt[k] = ORI_NEG;
      end else begin
        s3_ori_nxt[k] = ORI_POS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[3]) begin
      s3_ori_r <= s3_ori_nxt;
      s3_c1_r  <= WC'(s2_pc_r[0]) + WC'(s2_pc_r[1]);
      s3_c2_r  <= WC'(s2_pc_r[2]) + WC'(s2_pc_r[3]);
      s3_det_r <= WDET'(s2_pd1_r) - WDET'(s2_pd2_r);
      s3_a1_r  <= s2_a1_r;
      s3_b1_r  <= s2_b1_r;
      s3_a2_r  <= s2_a2_r;
      s3_b2_r  <= s2_b2_r;
      s3_box_r <= s2_box_r;
    end
  end

  // ---------------- stage 4: hit decision, numerator partial products
  logic                   s4_hit_nxt;
  logic signed [CH-1:0]   c1h, c2h;
  logic signed [C:0]      c1l, c2l;
  logic signed [PH-1:0]   s4_ph_nxt [4];
  logic signed [PL-1:0]   s4_pl_nxt [4];
  logic signed [PH-1:0]   s4_ph_r [4];
  logic signed [PL-1:0]   s4_pl_r [4];
  logic                   s4_hit_r, s4_detz_r;
  logic signed [WDET-1:0] s4_det_r;

  always_comb begin
    s4_hit_nxt = (s3_ori_r[0] != s3_ori_r[1] && s3_ori_r[2] != s3_ori_r[3])
              || (s3_ori_r[0] == ORI_COL && s3_box_r[0])
              || (s3_ori_r[1] == ORI_COL && s3_box_r[1])
              || (s3_ori_r[2] == ORI_COL && s3_box_r[2])
              || (s3_ori_r[3] == ORI_COL && s3_box_r[3]);
    // c split into signed high part and unsigned low C bits
    c1h = s3_c1_r[WC-1:C];
    c2h = s3_c2_r[WC-1:C];
    c1l = $signed({1'b0, s3_c1_r[C-1:0]});
    c2l = $signed({1'b0, s3_c2_r[C-1:0]});
    // 0: b2*c1  1: b1*c2  2: a1*c2  3: a2*c1
    s4_ph_nxt[0] = PH'(s3_b2_r) * PH'(c1h);
    s4_pl_nxt[0] = PL'(s3_b2_r) * PL'(c1l);
    s4_ph_nxt[1] = PH'(s3_b1_r) * PH'(c2h);
    s4_pl_nxt[1] = PL'(s3_b1_r) * PL'(c2l);
    s4_ph_nxt[2] = PH'(s3_a1_r) * PH'(c2h);
    s4_pl_nxt[2] = PL'(s3_a1_r) * PL'(c2l);
    s4_ph_nxt[3] = PH'(s3_a2_r) * PH'(c1h);
    s4_pl_nxt[3] = PL'(s3_a2_r) * PL'(c1l);
  end

  always_ff @(posedge clk) begin
    if (frdy[4]) begin
      s4_ph_r   <= s4_ph_nxt;
      s4_pl_r   <= s4_pl_nxt;
      s4_hit_r  <= s4_hit_nxt;
      s4_detz_r <= (s3_det_r == '0);
      s4_det_r  <= s3_det_r;
    end
  end

  // ---------------- stage 5: recombine partial products
  logic signed [WN-1:0]   s5_f_r [4];
  logic                   s5_hit_r, s5_detz_r;
  logic signed [WDET-1:0] s5_det_r;

  always_ff @(posedge clk) begin
    if (frdy[5]) begin
      for (int k = 0; k < 4; k++) begin
        s5_f_r[k] <= (WN'(s4_ph_r[k]) <<< C) + WN'(s4_pl_r[k]);
      end
      s5_hit_r  <= s4_hit_r;
      s5_detz_r <= s4_detz_r;
      s5_det_r  <= s4_det_r;
    end
  end

  // ---------------- stage 6: numerators
  logic signed [WN-1:0]   s6_nx_r, s6_ny_r;
  logic                   s6_hit_r, s6_detz_r;
  logic signed [WDET-1:0] s6_det_r;

  always_ff @(posedge clk) begin
    if (frdy[6]) begin
      s6_nx_r   <= s5_f_r[0] - s5_f_r[1];
      s6_ny_r   <= s5_f_r[2] - s5_f_r[3];
      s6_hit_r  <= s5_hit_r;
      s6_detz_r <= s5_detz_r;
      s6_det_r  <= s5_det_r;
    end
  end

  // ---------------- stage 7: magnitudes and quotient signs
  sip_ctl_t        s7_ctl_nxt, s7_ctl_r;
  logic [WN-1:0]   s7_ax_r, s7_ay_r;
  logic [WDET-1:0] s7_ad_r;

  always_comb begin
    s7_ctl_nxt       = '0;
    s7_ctl_nxt.hit   = s6_hit_r;
    s7_ctl_nxt.par   = s6_detz_r;
    s7_ctl_nxt.neg_x = s6_nx_r[WN-1] ^ s6_det_r[WDET-1];
    s7_ctl_nxt.neg_y = s6_ny_r[WN-1] ^ s6_det_r[WDET-1];
  end

  always_ff @(posedge clk) begin
    if (frdy[7]) begin
      s7_ctl_r <= s7_ctl_nxt;
      s7_ax_r  <= s6_nx_r[WN-1] ? WN'(-s6_nx_r) : WN'(s6_nx_r);
      s7_ay_r  <= s6_ny_r[WN-1] ? WN'(-s6_ny_r) : WN'(s6_ny_r);
      s7_ad_r  <= s6_det_r[WDET-1] ? WDET'(-s6_det_r) : WDET'(s6_det_r);
    end
  end

  // ---------------- stage 8: saturation check, quotient of 2^(C-1) or more
  logic [WN-1:0]   dlim;
  sip_ctl_t        s8_ctl_nxt, s8_ctl_r;
  logic [WN-1:0]   s8_ax_r, s8_ay_r;
  logic [WDET-1:0] s8_ad_r;

  always_comb begin
    dlim             = WN'(s7_ad_r) << Q;
    s8_ctl_nxt       = s7_ctl_r;
    s8_ctl_nxt.sat_x = s7_ax_r >= dlim;
    s8_ctl_nxt.sat_y = s7_ay_r >= dlim;
  end

  always_ff @(posedge clk) begin
    if (frdy[8]) begin
      s8_ctl_r <= s8_ctl_nxt;
      s8_ax_r  <= s7_ax_r;
      s8_ay_r  <= s7_ay_r;
      s8_ad_r  <= s7_ad_r;
    end
  end

  // ---------------- divider
  sip_ctl_t     dv_ctl;
  logic [Q-1:0] dv_qx, dv_qy;

  sip_div_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fv_r[NF]),
    .in_rdy  (div_in_rdy),
    .in_ctl  (s8_ctl_r),
    .in_nx   (s8_ax_r),
    .in_ny   (s8_ay_r),
    .in_d    (s8_ad_r),
    .out_vld (div_out_vld),
    .out_rdy (o_rdy),
    .out_ctl (dv_ctl),
    .out_qx  (dv_qx),
    .out_qy  (dv_qy)
  );

  // ---------------- output register: sign, saturation, special cases
  logic         o_v_r, o_hit_r, o_par_r;
  logic [C-1:0] o_px_r, o_py_r, px_nxt, py_nxt;

  assign o_rdy = !o_v_r || !out_stall;

  always_comb begin
    if (!dv_ctl.hit) begin
      px_nxt = '0;
      py_nxt = '0;
    end else if (dv_ctl.par) begin
      px_nxt = PAR_PT;
      py_nxt = PAR_PT;
    end else begin
      if (dv_ctl.sat_x) begin
        px_nxt = dv_ctl.neg_x ? C_MIN : C_MAX;
      end else begin
        px_nxt = dv_ctl.neg_x ? C'(-C'(dv_qx)) : C'(dv_qx);
      end
      if (dv_ctl.sat_y) begin
        py_nxt = dv_ctl.neg_y ? C_MIN : C_MAX;
      end else begin
        py_nxt = dv_ctl.neg_y ? C'(-C'(dv_qy)) : C'(dv_qy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= div_out_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_hit_r <= dv_ctl.hit;
      o_par_r <= dv_ctl.hit && dv_ctl.par;
      o_px_r  <= px_nxt;
      o_py_r  <= py_nxt;
    end
  end

  assign out_valid        = o_v_r;
  assign out_hit          = o_hit_r;
  assign out_parallel_hit = o_par_r;
  assign out_point_x      = o_px_r;
  assign out_point_y      = o_py_r;

  // ---------------- checks
  a_par_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_parallel_hit || out_hit))
    else $error("parallel flag without hit");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_point_x == '0 && out_point_y == '0))
    else $error("miss with nonzero point");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side moves");

  a_par_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_parallel_hit) |-> (out_point_x == out_point_y))
    else $error("collinear overlap point mismatch");

endmodule

/* sim/testbench.sv */
// Testbench for the segment intersection point core: predicts each result and checks it.
module testbench;
  import sip_pkg::*;

  localparam int CW = SIP_COORD_BITS;
  localparam int FW = SIP_FRAC_BITS;
  localparam int LATENCY = 8 + CW;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic hit;
    logic par;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } isect_t;

  // orientation codes
  typedef enum int {COLLINEAR = 0, ORIENT_POS = 1, ORIENT_NEG = 2} orient_t;

  // expected-result store and checker
  class isect_board;
    isect_t pending[$];
    int errors;

    function orient_t orient(longint px, longint py, longint qx, longint qy,
                             longint rx, longint ry);
      logic signed [127:0] v;
      v = 128'(signed'(qy - py)) * 128'(signed'(rx - qx))
          - 128'(signed'(qx - px)) * 128'(signed'(ry - qy));
      if (v == 0) return COLLINEAR;
      return (v < 0) ? ORIENT_NEG : ORIENT_POS;
    endfunction

    function bit on_box(longint px, longint py, longint qx, longint qy,
                        longint rx, longint ry);
      longint xl, xh, yl, yh;
      xl = (px < rx) ? px : rx;
      xh = (px < rx) ? rx : px;
      yl = (py < ry) ? py : ry;
      yh = (py < ry) ? ry : py;
      return qx >= xl && qx <= xh && qy >= yl && qy <= yh;
    endfunction

    function logic signed [CW-1:0] clamp(logic signed [127:0] v);
      if (v > CMAX) return CW'(CMAX);
      if (v < CMIN) return CW'(CMIN);
      return v[CW-1:0];
    endfunction

    // note an accepted segment pair
    function void note_pair(longint x[4], longint y[4]);
      isect_t e;
      orient_t o1, o2, o3, o4;
      logic signed [127:0] a1, b1, a2, b2, c1, c2, det;
      o1 = orient(x[0], y[0], x[1], y[1], x[2], y[2]);
      o2 = orient(x[0], y[0], x[1], y[1], x[3], y[3]);
      o3 = orient(x[2], y[2], x[3], y[3], x[0], y[0]);
      o4 = orient(x[2], y[2], x[3], y[3], x[1], y[1]);
      e.hit = (o1 != o2 && o3 != o4)
           || (o1 == COLLINEAR && on_box(x[0], y[0], x[2], y[2], x[1], y[1]))
           || (o2 == COLLINEAR && on_box(x[0], y[0], x[3], y[3], x[1], y[1]))
           || (o3 == COLLINEAR && on_box(x[2], y[2], x[0], y[0], x[3], y[3]))
           || (o4 == COLLINEAR && on_box(x[2], y[2], x[1], y[1], x[3], y[3]));
      e.par = 0;
      e.px = '0;
      e.py = '0;
      if (e.hit) begin
        a1 = y[1] - y[0];
        b1 = x[0] - x[1];
        a2 = y[3] - y[2];
        b2 = x[2] - x[3];
        c1 = a1 * 128'(signed'(x[0])) + b1 * 128'(signed'(y[0]));
        c2 = a2 * 128'(signed'(x[2])) + b2 * 128'(signed'(y[2]));
        det = a1 * b2 - a2 * b1;
        if (det == 0) begin
          e.par = 1;
          e.px = -(CW'(1) << FW);
          e.py = e.px;
        end else begin
          e.px = clamp((b2 * c1 - b1 * c2) / det);
          e.py = clamp((a1 * c2 - a2 * c1) / det);
        end
      end
      pending = {pending, e};
    endfunction

    // compare one result word with the oldest expectation
    function void check_word(isect_t got);
      isect_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b par=%0b x=%0d y=%0d",
                 $time, got.hit, got.par, got.px, got.py);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, got.hit);
        errors++;
      end
      if (got.par !== e.par) begin
        $display("%0t: parallel_hit expected %0b actual %0b", $time, e.par, got.par);
        errors++;
      end
      if (got.px !== e.px) begin
        $display("%0t: point_x expected %0d actual %0d", $time, e.px, got.px);
        errors++;
      end
      if (got.py !== e.py) begin
        $display("%0t: point_y expected %0d actual %0d", $time, e.py, got.py);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] in_a_start_x = '0, in_a_start_y = '0, in_a_end_x = '0, in_a_end_y = '0;
  logic signed [CW-1:0] in_b_start_x = '0, in_b_start_y = '0, in_b_end_x = '0, in_b_end_y = '0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit, out_parallel_hit;
  logic signed [CW-1:0] out_point_x, out_point_y;

  isect_board board = new();
  int send_idle_pct = 16;
  int recv_idle_pct = 72;
  longint cycles = 0;

  segment_intersection_point_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stall, check on acceptance
  always @(posedge clk) begin
    isect_t got;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got.hit = out_hit;
      got.par = out_parallel_hit;
      got.px = out_point_x;
      got.py = out_point_y;
      board.check_word(got);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // drive one pair; returns after it is accepted, valid still high
  task automatic send_pair(longint x[4], longint y[4]);
    // idle cycles before the word
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_a_start_x <= CW'(x[0]);
    in_a_start_y <= CW'(y[0]);
    in_a_end_x <= CW'(x[1]);
    in_a_end_y <= CW'(y[1]);
    in_b_start_x <= CW'(x[2]);
    in_b_start_y <= CW'(y[2]);
    in_b_end_x <= CW'(x[3]);
    in_b_end_y <= CW'(y[3]);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pair(x, y);
  endtask

  function automatic longint rand_coord(int mode);
    case (mode)
      0: return $signed(CW'($urandom));
      1: return longint'($urandom_range(64)) - 32;
      2: return ($urandom_range(1)) ? CMAX : CMIN;
      default: return longint'($urandom_range(8000)) - 4000;
    endcase
  endfunction

  task automatic send_random();
    longint x[4], y[4];
    longint t;
    int kind, m;
    kind = $urandom_range(9);
    m = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      x[i] = rand_coord(m == 2 && $urandom_range(1) ? 2 : m);
      y[i] = rand_coord(m == 2 && $urandom_range(1) ? 2 : m);
    end
    case (kind)
      // collinear: B lies on A's line at integer steps
      0, 1: begin
        longint dx, dy;
        dx = longint'($urandom_range(40)) - 20;
        dy = longint'($urandom_range(40)) - 20;
        x[1] = x[0] + dx * 4; y[1] = y[0] + dy * 4;
        t = longint'($urandom_range(8)) - 2;
        x[2] = x[0] + dx * t; y[2] = y[0] + dy * t;
        t = longint'($urandom_range(8)) - 2;
        x[3] = x[0] + dx * t; y[3] = y[0] + dy * t;
      end
      // shared end point
      2: begin x[2] = x[1]; y[2] = y[1]; end
      // degenerate B
      3: begin x[3] = x[2]; y[3] = y[2]; end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      if (x[i] > CMAX) x[i] = CMAX;
      if (x[i] < CMIN) x[i] = CMIN;
      if (y[i] > CMAX) y[i] = CMAX;
      if (y[i] < CMIN) y[i] = CMIN;
    end
    send_pair(x, y);
  endtask

  task automatic send_directed();
    longint x[4], y[4];
    // crossing X
    x = '{0, 2560, 0, 2560}; y = '{0, 2560, 2560, 0}; send_pair(x, y);
    // disjoint parallel
    x = '{0, 2560, 0, 2560}; y = '{0, 0, 256, 256}; send_pair(x, y);
    // collinear overlap
    x = '{0, 2560, 1280, 3840}; y = '{0, 0, 0, 0}; send_pair(x, y);
    // collinear disjoint
    x = '{0, 256, 512, 768}; y = '{0, 0, 0, 0}; send_pair(x, y);
    // touching at end point (T)
    x = '{0, 2560, 1280, 1280}; y = '{0, 0, 0, 2560}; send_pair(x, y);
    // degenerate point on segment, and off it
    x = '{0, 2560, 512, 512}; y = '{0, 2560, 512, 512}; send_pair(x, y);
    x = '{0, 2560, 512, 512}; y = '{0, 2560, 600, 600}; send_pair(x, y);
    // both degenerate, same point
    x = '{77, 77, 77, 77}; y = '{-5, -5, -5, -5}; send_pair(x, y);
    // extremes crossing through the whole range
    x = '{CMIN, CMAX, CMIN, CMAX}; y = '{CMIN, CMAX, CMAX, CMIN}; send_pair(x, y);
    x = '{CMIN, CMIN, CMAX, CMAX}; y = '{CMIN, CMAX, CMIN, CMAX}; send_pair(x, y);
    x = '{CMAX, CMAX, CMAX, CMAX}; y = '{CMIN, CMAX, 0, CMAX}; send_pair(x, y);
    x = '{-1, 1, 1, -1}; y = '{-1, 1, -1, 1}; send_pair(x, y);
    // negative quotient truncation
    x = '{-3, 4, -3, 4}; y = '{0, 7, 5, -1}; send_pair(x, y);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    board.errors = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_directed();
    for (int i = 0; i < 300; i++) send_random();
    // hold off until the pipeline is empty
    drain();
    send_idle_pct = 72;
    recv_idle_pct = 16;
    for (int i = 0; i < 300; i++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 300; i++) send_random();
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
